### hdl/itd_pkg.sv
// itd_pkg: shared constants, types and the digit-to-character function
// for the integer-to-text digits unit. No dependencies.
`timescale 1ns / 1ps

package itd_pkg;

   localparam int DEFAULT_MAX_DIGITS = 32;
   localparam int DEFAULT_VALUE_BITS = 32;

   localparam int RADIX_W = 6;
   localparam int DIGIT_W = 6;
   localparam int CHAR_W  = 7;

   localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
   localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
   localparam logic [RADIX_W-1:0] DECIMAL     = 6'd10;

   localparam logic [CHAR_W-1:0] CH_ZERO    = 7'h30;
   localparam logic [CHAR_W-1:0] CH_LOWER_A = 7'h61;
   localparam logic [CHAR_W-1:0] CH_MINUS   = 7'h2D;
   localparam logic [DIGIT_W-1:0] DIGIT_NINE = 6'd9;
   localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 6'd10;

   // quotient bits resolved per divider cycle
   localparam int BITS_PER_STEP = 8;

   typedef struct packed {
      logic done;
      logic quotient_zero;
   } div_status_type;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
      logic [DIGIT_W-1:0] off;
      off = d - DIGIT_TEN;
      if (d > DIGIT_NINE) begin
         digit_char = CH_LOWER_A + {1'b0, off};
      end else begin
         digit_char = CH_ZERO + {1'b0, d};
      end
   endfunction

endpackage

### hdl/integer_to_text_digits_unit.sv
// integer_to_text_digits_unit: integer to ASCII text in base 2..36, signed in decimal only.
// Each digit takes one divider run of STEPS = ceil(VALUE_BITS/8) iterations (4 at 32 bits),
//   then the characters stream out one per cycle.
// Throughput: one transaction per conversion; busy holds until the last read.
// Reset: synchronous, active high; radix returns to 10, sequencer to idle.
// Characters stream out as one-cycle strobes; the receiver cannot stall.
// Depends on itd_pkg, itd_divider, itd_ram.
`timescale 1ns / 1ps

module integer_to_text_digits_unit #(
   parameter int MAX_DIGITS = itd_pkg::DEFAULT_MAX_DIGITS,
   parameter int VALUE_BITS = itd_pkg::DEFAULT_VALUE_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   // input transaction
   input  logic                             start,
   output logic                             busy,
   input  logic signed [VALUE_BITS-1:0]     req_value,
   // result transactions
   output logic                             rsp_strobe,
   output logic [itd_pkg::CHAR_W-1:0]       rsp_text_char,
   output logic                             rsp_is_last,
   // radix register
   input  logic                             csr_write_enable,
   input  logic [itd_pkg::RADIX_W-1:0]      csr_write_data
);

   localparam int AW = $clog2(MAX_DIGITS);
   localparam int CW = $clog2(MAX_DIGITS + 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DIVIDE = 2'd1;
   localparam logic [1:0] ST_EMIT   = 2'd2;

   logic [1:0]                    state_ff, state_in;
   logic [itd_pkg::RADIX_W-1:0]   radix_ff;
   logic [itd_pkg::RADIX_W-1:0]   base_ff, base_in, base_eff;
   logic                          neg_ff, neg_in;
   logic [CW-1:0]                 cnt_ff, cnt_in, cnt_next;
   logic [AW-1:0]                 ptr_ff, ptr_in;
   logic                          sign_ff, sign_in;
   logic                          rd_pend_ff, rd_pend_in;
   logic                          rd_last_ff, rd_last_in;

   logic                          accept;
   logic                          neg_now;
   logic [VALUE_BITS-1:0]         magnitude;
   logic                          div_load;
   logic [VALUE_BITS-1:0]         div_dividend;
   logic [VALUE_BITS-1:0]         div_quotient;
   logic [itd_pkg::DIGIT_W-1:0]   div_remainder;
   itd_pkg::div_status_type       div_status;
   logic                          ram_wr_en;
   logic                          ram_rd_en;
   logic [itd_pkg::DIGIT_W-1:0]   ram_rd_data;
   logic                          stop;

   // radix register: the user must write it only while idle; the block does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= itd_pkg::RADIX_RESET;
      end else if (csr_write_enable) begin
         radix_ff <= csr_write_data;
      end
   end

   // clamp out-of-range bases to 2 and 36
   always_comb begin
      if (radix_ff < itd_pkg::RADIX_MIN) begin
         base_eff = itd_pkg::RADIX_MIN;
      end else if (radix_ff > itd_pkg::RADIX_MAX) begin
         base_eff = itd_pkg::RADIX_MAX;
      end else begin
         base_eff = radix_ff;
      end
   end

   assign accept    = start && !busy;
   // sign only in decimal; other bases read the value as unsigned
   assign neg_now   = (base_eff == itd_pkg::DECIMAL) && req_value[VALUE_BITS-1];
   // the most negative value negates to itself, which is 2^(N-1) unsigned
   assign magnitude = neg_now ? (~req_value + VALUE_BITS'(1)) : req_value;

   assign cnt_next  = cnt_ff + CW'(1);
   assign stop      = div_status.quotient_zero || (cnt_next == CW'(MAX_DIGITS));

   // sequencer: divide repeatedly, storing digits low first, then read back high first
   always_comb begin
      state_in     = state_ff;
      base_in      = base_ff;
      neg_in       = neg_ff;
      cnt_in       = cnt_ff;
      ptr_in       = ptr_ff;
      sign_in      = 1'b0;
      rd_pend_in   = 1'b0;
      rd_last_in   = 1'b0;
      div_load     = 1'b0;
      div_dividend = div_quotient;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               base_in      = base_eff;
               neg_in       = neg_now;
               cnt_in       = '0;
               div_load     = 1'b1;
               div_dividend = magnitude;
               state_in     = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               // store this digit; zero input still yields one '0'
               ram_wr_en = 1'b1;
               cnt_in    = cnt_next;
               if (stop) begin
                  ptr_in   = cnt_ff[AW-1:0];
                  sign_in  = neg_ff;
                  state_in = ST_EMIT;
               end else begin
                  div_load = 1'b1;
               end
            end
         end
         ST_EMIT: begin
            ram_rd_en  = 1'b1;
            rd_pend_in = 1'b1;
            rd_last_in = (ptr_ff == '0);
            if (ptr_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               ptr_in = ptr_ff - AW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         neg_ff     <= 1'b0;
         cnt_ff     <= '0;
         sign_ff    <= 1'b0;
         rd_pend_ff <= 1'b0;
         rd_last_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         neg_ff     <= neg_in;
         cnt_ff     <= cnt_in;
         sign_ff    <= sign_in;
         rd_pend_ff <= rd_pend_in;
         rd_last_ff <= rd_last_in;
      end
      base_ff <= base_in;
      ptr_ff  <= ptr_in;
   end

   itd_divider #(
      .VALUE_BITS(VALUE_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .load     (div_load),
      .dividend (div_dividend),
      .divisor  (base_in),
      .quotient (div_quotient),
      .remainder(div_remainder),
      .status   (div_status)
   );

   itd_ram #(
      .WIDTH(itd_pkg::DIGIT_W),
      .DEPTH(MAX_DIGITS)
   ) u_digit_store (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(cnt_ff[AW-1:0]),
      .wr_data(div_remainder),
      .rd_en  (ram_rd_en),
      .rd_addr(ptr_ff),
      .rd_data(ram_rd_data)
   );

   assign busy          = (state_ff != ST_IDLE);
   // a negative value's sign goes out in the first emit cycle, digits follow from the store
   assign rsp_strobe    = sign_ff || rd_pend_ff;
   assign rsp_text_char = sign_ff ? itd_pkg::CH_MINUS : itd_pkg::digit_char(ram_rd_data);
   assign rsp_is_last   = rd_pend_ff && rd_last_ff;

   a_sign_digit_excl: assert property (@(posedge clock) disable iff (reset)
      !(sign_ff && rd_pend_ff))
      else $error("sign and digit emitted in the same cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("transaction accepted without going busy");

   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == ST_DIVIDE))
      else $error("divider finished outside the divide phase");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_DIGITS))
      else $error("digit count exceeds store depth");

   a_last_ends_emit: assert property (@(posedge clock) disable iff (reset)
      rd_last_in && rd_pend_in |=> (state_ff == ST_IDLE))
      else $error("last character read but sequencer not idle");

endmodule

### hdl/itd_ram.sv
// itd_ram: generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module itd_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/itd_divider.sv
// itd_divider: iterative restoring divider, unsigned dividend by a 6-bit base,
// BITS_PER_STEP quotient bits per cycle. Depends on itd_pkg.
`timescale 1ns / 1ps

module itd_divider #(
   parameter int VALUE_BITS = itd_pkg::DEFAULT_VALUE_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             load,
   input  logic [VALUE_BITS-1:0]            dividend,
   input  logic [itd_pkg::RADIX_W-1:0]      divisor,
   output logic [VALUE_BITS-1:0]            quotient,
   output logic [itd_pkg::DIGIT_W-1:0]      remainder,
   output itd_pkg::div_status_type          status
);

   localparam int BPS   = itd_pkg::BITS_PER_STEP;
   localparam int STEPS = (VALUE_BITS + BPS - 1) / BPS;
   localparam int PAD_W = STEPS * BPS;
   localparam int CNT_W = $clog2(STEPS + 1);
   localparam int RW    = itd_pkg::DIGIT_W;

   logic [PAD_W-1:0] work_ff, work_in;
   logic [RW-1:0]    rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;

   // one cycle of the unrolled subtract chain: BPS restoring steps
   always_comb begin
      logic [PAD_W-1:0] w;
      logic [RW-1:0]    r;
      logic [RW:0]      r7;
      w = work_ff;
      r = rem_ff;
      for (int i = 0; i < BPS; i++) begin
         r7 = {r, w[PAD_W-1]};
         w  = {w[PAD_W-2:0], 1'b0};
         if (r7 >= {1'b0, divisor}) begin
            r7   = r7 - {1'b0, divisor};
            w[0] = 1'b1;
         end
         r = r7[RW-1:0];
      end
      work_in = work_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (load) begin
         work_in = PAD_W'(dividend);
         rem_in  = '0;
         cnt_in  = CNT_W'(STEPS);
         run_in  = 1'b1;
      end else if (run_ff) begin
         work_in = w;
         rem_in  = r;
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
   end

   assign quotient             = work_ff[VALUE_BITS-1:0];
   assign remainder            = rem_ff;
   assign status.done          = done_ff;
   assign status.quotient_zero = (work_ff == '0);

endmodule
